// ----- src/mrt_pkg.sv -----
// Shared types and codes for the metric-sorted route table.
package mrt_pkg;

  // Default number of table cells
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_CLR = 2'd2,
    OP_QRY = 2'd3
  } op_t;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Input beat
  typedef struct packed {
    op_t         operation;
    logic [31:0] dest_addr;
    logic [5:0]  prefix_len;
    logic [31:0] gateway_addr;
    logic [31:0] route_metric;
    logic [7:0]  route_protocol;
    logic [7:0]  route_scope;
    logic [7:0]  route_kind;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] out_dest_addr;
    logic [5:0]  out_prefix_len;
    logic [31:0] out_gateway_addr;
    logic [31:0] out_metric;
    logic [7:0]  out_protocol;
    logic [7:0]  out_scope;
    logic [7:0]  out_kind;
  } out_item_t;

  // One stored route
  typedef struct packed {
    logic [31:0] dest;
    logic [5:0]  prefix;
    logic [31:0] gateway;
    logic [31:0] metric;
    logic [7:0]  protocol;
    logic [7:0]  scope;
    logic [7:0]  kind;
  } entry_t;

  // What a cell hands to its neighbours
  typedef struct packed {
    logic   occ;
    entry_t entry;
  } link_t;

  // Ripple signals running from cell 0 towards the tail
  typedef struct packed {
    logic ins;        // this cell takes part in the insert shift
    logic del_seen;   // a delete match at or before this cell
    logic dflt_seen;  // a default route at or before this cell
  } chain_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic   do_add;
    logic   do_del;
    logic   do_clr;
    entry_t key;
  } ctl_t;

endpackage

// ----- src/metric_sorted_route_table.sv -----
// Top level: command register, row of route cells and result register.
//
//  channel | ports                 | handshake
//  --------+-----------------------+-------------------------------------
//  input   | start, busy, in_item  | beat taken when start && !busy
//  result  | out_valid, out_item   | one-cycle strobe, no backpressure
//
// For every operation the accept edge registers the command; in S_EXEC all cells
// then update at once (compare plus ripple chain across the row) and the result is
// registered, which shows for one cycle after that.
// A new command may be accepted while that result is showing.
// Reset empties the table; stored route payloads are not cleared.
module metric_sorted_route_table #(
  parameter int unsigned TABLE_DEPTH = mrt_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mrt_pkg::in_item_t  in_item,
  output logic               out_valid,
  output mrt_pkg::out_item_t out_item
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  mrt_pkg::in_item_t  cmd_r;
  logic               out_valid_r;
  mrt_pkg::out_item_t out_item_r, out_item_nxt;
  mrt_pkg::ctl_t      ctl;
  mrt_pkg::chain_t    chain [TABLE_DEPTH+1];
  mrt_pkg::link_t     self  [TABLE_DEPTH];
  logic               sel   [TABLE_DEPTH];
  mrt_pkg::entry_t    hit_entry;
  logic               exec, full;

  assign busy = (state_r != S_IDLE);
  assign exec = (state_r == S_EXEC);
  assign full = self[TABLE_DEPTH-1].occ;

  // Control FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= exec;
    end
  end

  // Command register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= in_item;
    end
  end

  // Broadcast command to the cells
  always_comb begin
    ctl.do_add       = exec && (cmd_r.operation == mrt_pkg::OP_ADD) && !full;
    ctl.do_del       = exec && (cmd_r.operation == mrt_pkg::OP_DEL);
    ctl.do_clr       = exec && (cmd_r.operation == mrt_pkg::OP_CLR);
    ctl.key.dest     = cmd_r.dest_addr;
    ctl.key.prefix   = cmd_r.prefix_len;
    ctl.key.gateway  = cmd_r.gateway_addr;
    ctl.key.metric   = cmd_r.route_metric;
    ctl.key.protocol = cmd_r.route_protocol;
    ctl.key.scope    = cmd_r.route_scope;
    ctl.key.kind     = cmd_r.route_kind;
  end

  assign chain[0] = '0;

  // Row of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mrt_pkg::link_t left_l, right_l;
    if (i == 0) begin : g_head
      assign left_l = '0;
    end else begin : g_body
      assign left_l = self[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_l = '0;
    end else begin : g_mid
      assign right_l = self[i+1];
    end
    mrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .left_i  (left_l),
      .right_i (right_l),
      .chain_i (chain[i]),
      .chain_o (chain[i+1]),
      .self_o  (self[i]),
      .sel_o   (sel[i])
    );
  end

  // Pick the first default route (select is one-hot or empty)
  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_entry = hit_entry | (sel[i] ? self[i].entry : '0);
    end
  end

  // Result beat
  always_comb begin
    out_item_nxt        = '0;
    out_item_nxt.status = mrt_pkg::ST_OK;
    unique case (cmd_r.operation)
      mrt_pkg::OP_ADD: begin
        if (full) out_item_nxt.status = mrt_pkg::ST_FULL;
      end
      mrt_pkg::OP_DEL: begin
        if (!chain[TABLE_DEPTH].del_seen) out_item_nxt.status = mrt_pkg::ST_NOT_FOUND;
      end
      mrt_pkg::OP_CLR: begin
        out_item_nxt.status = mrt_pkg::ST_OK;
      end
      mrt_pkg::OP_QRY: begin
        if (chain[TABLE_DEPTH].dflt_seen) begin
          out_item_nxt.found            = 1'b1;
          out_item_nxt.out_dest_addr    = hit_entry.dest;
          out_item_nxt.out_prefix_len   = hit_entry.prefix;
          out_item_nxt.out_gateway_addr = hit_entry.gateway;
          out_item_nxt.out_metric       = hit_entry.metric;
          out_item_nxt.out_protocol     = hit_entry.protocol;
          out_item_nxt.out_scope        = hit_entry.scope;
          out_item_nxt.out_kind         = hit_entry.kind;
        end else begin
          out_item_nxt.status = mrt_pkg::ST_NOT_FOUND;
        end
      end
      default: out_item_nxt.status = mrt_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- src/mrt_cell.sv -----
// One table cell: holds a route, compares it with the command, shifts with its neighbours.
module mrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  mrt_pkg::ctl_t   ctl,
  input  mrt_pkg::link_t  left_i,
  input  mrt_pkg::link_t  right_i,
  input  mrt_pkg::chain_t chain_i,
  output mrt_pkg::chain_t chain_o,
  output mrt_pkg::link_t  self_o,
  output logic            sel_o
);

  logic           occ_r, occ_nxt;
  mrt_pkg::entry_t entry_r, entry_nxt;
  logic           gt, ins, match, dflt;

  // Local compares against the broadcast key
  always_comb begin
    gt    = occ_r && (entry_r.metric > ctl.key.metric);
    ins   = !occ_r || gt;
    match = occ_r && (entry_r.prefix == ctl.key.prefix) && (entry_r.dest == ctl.key.dest) &&
            (entry_r.gateway == ctl.key.gateway) && (entry_r.metric == ctl.key.metric);
    dflt  = occ_r && (entry_r.dest == 32'd0) && (entry_r.gateway != 32'd0);
  end

  // Ripple outputs
  always_comb begin
    chain_o.ins       = ins;
    chain_o.del_seen  = chain_i.del_seen || match;
    chain_o.dflt_seen = chain_i.dflt_seen || dflt;
    sel_o             = dflt && !chain_i.dflt_seen;
    self_o.occ        = occ_r;
    self_o.entry      = entry_r;
  end

  // Next state: clear, shift right on insert, shift left on delete
  always_comb begin
    occ_nxt   = occ_r;
    entry_nxt = entry_r;
    priority if (ctl.do_clr) begin
      occ_nxt = 1'b0;
    end else if (ctl.do_add) begin
      if (chain_i.ins) begin
        occ_nxt   = left_i.occ;
        entry_nxt = left_i.entry;
      end else if (ins) begin
        occ_nxt   = 1'b1;
        entry_nxt = ctl.key;
      end
    end else if (ctl.do_del && chain_o.del_seen) begin
      occ_nxt   = right_i.occ;
      entry_nxt = right_i.entry;
    end else begin
      // nothing to do: hold
      occ_nxt   = occ_r;
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
